// ===== rtl/prr_pkg.sv =====
// shared constants, widths and types of the polyphase rational resampler
`default_nettype none

package prr_pkg;

   // filter geometry
   localparam int HALF_TAPS   = 16;
   localparam int MAX_PHASES  = 1024;
   localparam int TAP_COUNT   = 2 * HALF_TAPS + 1;
   localparam int STORE_DEPTH = MAX_PHASES * TAP_COUNT;
   localparam int BURST_LIMIT = 64;
   localparam int STEP_LIMIT  = 1024;

   // fixed field widths
   localparam int SAMPLE_W  = 24;
   localparam int COEFF_W   = 18;
   localparam int CADDR_W   = 16;
   localparam int CFG_W     = 11;
   localparam int CSR_IDX_W = 1;

   // derived widths
   localparam int HIST_AW  = (TAP_COUNT > 1) ? $clog2(TAP_COUNT) : 1;
   localparam int STORE_AW = $clog2(STORE_DEPTH);
   localparam int CPTR_W   = $clog2(STORE_DEPTH + 1);
   localparam int TAP_W    = $clog2(TAP_COUNT);
   localparam int PHASE_W  = $clog2(MAX_PHASES + 1);
   localparam int STEP_W   = $clog2(STEP_LIMIT + 1);
   localparam int BURST_W  = $clog2(BURST_LIMIT + 1);
   localparam int CNT_W    = $clog2(MAX_PHASES * STEP_LIMIT + STEP_LIMIT + 1);
   localparam int PROD_W   = COEFF_W + SAMPLE_W;
   localparam int ACC_W    = PROD_W + $clog2(TAP_COUNT);

   // rounding and saturation of the Q9.39 sum to Q1.23
   localparam int FRAC_SHIFT = 16;
   localparam int ROUND_BIAS = 2 ** (FRAC_SHIFT - 1);
   localparam int SAMPLE_MAX = 2 ** (SAMPLE_W - 1) - 1;
   localparam int SAMPLE_MIN = -(2 ** (SAMPLE_W - 1));

   // item operations
   localparam logic OP_SAMPLE = 1'b0;
   localparam logic OP_COEFF  = 1'b1;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] REG_SOURCE_STEP   = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_RESULT_PHASES = 1'b1;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_MAC,
      ST_DRAIN,
      ST_RESULT,
      ST_FINISH
   } seq_state_type;

endpackage

`default_nettype wire

// ===== rtl/polyphase_rational_resampler.sv =====
// top level of the polyphase rational resampler, one audio channel
// first result of a sample item passes the check, mac and drain states, then the result register
// a sample item holds the block, req_ready low, until its results are loaded;
//   a coefficient item is written while idle and the block stays ready; the single
//   multiply-accumulate over the coefficient memory, one tap a cycle, paces each result
// reset: history reads as zero, frame counters clear, source_step and result_phases are 1;
//   coefficient memory is not cleared and no clearing pass is run
`default_nettype none

module polyphase_rational_resampler (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // input item channel
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic                              req_op,
   input  wire logic signed [prr_pkg::SAMPLE_W-1:0] req_sample_in,
   input  wire logic [prr_pkg::CADDR_W-1:0]       req_coeff_addr,
   input  wire logic signed [prr_pkg::COEFF_W-1:0]  req_coeff_value,
   // result item channel
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic signed [prr_pkg::SAMPLE_W-1:0]    rsp_sample_out,
   output logic                                   rsp_last,
   // configuration write port
   input  wire logic                              csr_we,
   input  wire logic [prr_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [prr_pkg::CFG_W-1:0]         csr_wdata
);

   import prr_pkg::*;

   localparam int SH_W = ACC_W - FRAC_SHIFT + 1;
   localparam logic signed [SH_W-1:0] SAT_HI = SH_W'(SAMPLE_MAX);
   localparam logic signed [SH_W-1:0] SAT_LO = SH_W'(SAMPLE_MIN);

   seq_state_type state_ff, state_in;

   // configuration
   logic [CFG_W-1:0] src_step_ff, src_step_in;
   logic [CFG_W-1:0] res_phases_ff, res_phases_in;

   // frame counters
   logic [PHASE_W-1:0] next_phase_ff, next_phase_in;
   logic [CNT_W-1:0]   phase_prod_ff, phase_prod_in;
   logic [CNT_W-1:0]   sample_bound_ff, sample_bound_in;
   logic [STEP_W-1:0]  frame_pos_ff, frame_pos_in;
   logic [BURST_W-1:0] burst_cnt_ff, burst_cnt_in;

   // memory pointers
   logic [CPTR_W-1:0]    cptr_ff, cptr_in;
   logic [HIST_AW-1:0]   wptr_ff, wptr_in;
   logic [HIST_AW-1:0]   hptr_ff, hptr_in;
   logic [TAP_W-1:0]     tap_ff, tap_in;
   logic [TAP_COUNT-1:0] hist_valid_ff, hist_valid_in;

   // mac pipeline
   logic                     rd_valid_ff, hval_ff, prod_valid_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;

   // output register
   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_W-1:0] rsp_sample_ff;
   logic                       rsp_last_ff;

   // effective ratio
   logic [STEP_W-1:0]  p_eff;
   logic [PHASE_W-1:0] q_eff;

   // sequencer controls
   logic accept, coeff_wr, hist_wr, mac_issue, mac_start, rsp_load, frame_step, rsp_free;
   logic phase_ok, more_ok, mac_last, drain_done;

   // memory read data
   logic signed [COEFF_W-1:0]  coef_rd;
   logic signed [SAMPLE_W-1:0] hist_rd;

   // rounding
   logic signed [ACC_W:0]      acc_bias;
   logic signed [SH_W-1:0]     acc_shift;
   logic signed [SAMPLE_W-1:0] acc_sat;

   // frame step values
   logic [STEP_W:0] frame_pos_next;
   logic [CNT_W:0]  bound_sum, bound_sum_next;
   logic [CNT_W:0]  prod_next;

   // effective p and q, zero treated as one and clamped
   always_comb begin
      int p_val;
      int q_val;
      p_val = int'(src_step_ff);
      q_val = int'(res_phases_ff);
      if (p_val == 0) p_val = 1;
      if (p_val > STEP_LIMIT) p_val = STEP_LIMIT;
      if (q_val == 0) q_val = 1;
      if (q_val > MAX_PHASES) q_val = MAX_PHASES;
      if (q_val > BURST_LIMIT * p_val) q_val = BURST_LIMIT * p_val;
      p_eff = STEP_W'(p_val);
      q_eff = PHASE_W'(q_val);
   end

   // phase tests for the current and the following phase
   assign bound_sum = (CNT_W + 1)'(sample_bound_ff) + (CNT_W + 1)'(q_eff);
   assign prod_next = (CNT_W + 1)'(phase_prod_ff) + (CNT_W + 1)'(p_eff);
   assign phase_ok  = (next_phase_ff < q_eff)
                    && ((CNT_W + 1)'(phase_prod_ff) < bound_sum)
                    && (burst_cnt_ff < BURST_W'(BURST_LIMIT));
   assign more_ok   = ((PHASE_W + 1)'(next_phase_ff) + 1'b1 < (PHASE_W + 1)'(q_eff))
                    && (prod_next < bound_sum)
                    && ((BURST_W + 1)'(burst_cnt_ff) + 1'b1 < (BURST_W + 1)'(BURST_LIMIT));

   assign mac_last   = (tap_ff == TAP_W'(TAP_COUNT - 1));
   assign drain_done = !rd_valid_ff && !prod_valid_ff;
   assign rsp_free   = !rsp_valid_ff || rsp_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_op == OP_SAMPLE) state_in = ST_CHECK;
         end
         ST_CHECK: begin
            state_in = phase_ok ? ST_MAC : ST_FINISH;
         end
         ST_MAC: begin
            if (mac_last) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            if (drain_done) state_in = ST_RESULT;
         end
         ST_RESULT: begin
            if (rsp_free) state_in = more_ok ? ST_MAC : ST_FINISH;
         end
         ST_FINISH: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_ready  = 1'b0;
      mac_issue  = 1'b0;
      mac_start  = 1'b0;
      rsp_load   = 1'b0;
      frame_step = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
         end
         ST_CHECK: begin
            mac_start = phase_ok;
         end
         ST_MAC: begin
            mac_issue = 1'b1;
         end
         ST_DRAIN: begin
         end
         ST_RESULT: begin
            rsp_load  = rsp_free;
            mac_start = rsp_free && more_ok;
         end
         ST_FINISH: begin
            frame_step = 1'b1;
         end
         default: begin
         end
      endcase
   end

   assign accept   = req_valid && req_ready;
   assign coeff_wr = accept && req_op == OP_COEFF
                   && (32'(req_coeff_addr) < 32'(STORE_DEPTH));
   assign hist_wr  = accept && req_op == OP_SAMPLE;

   // coefficient memory
   prr_ram #(
      .WIDTH (COEFF_W),
      .DEPTH (STORE_DEPTH)
   ) u_coeff_ram (
      .clock   (clock),
      .wr_en   (coeff_wr),
      .wr_addr (STORE_AW'(req_coeff_addr)),
      .wr_data (req_coeff_value),
      .rd_en   (mac_issue),
      .rd_addr (cptr_ff[STORE_AW-1:0]),
      .rd_data (coef_rd)
   );

   // sample history, circular
   prr_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (TAP_COUNT)
   ) u_hist_ram (
      .clock   (clock),
      .wr_en   (hist_wr),
      .wr_addr (wptr_ff),
      .wr_data (req_sample_in),
      .rd_en   (mac_issue),
      .rd_addr (hptr_ff),
      .rd_data (hist_rd)
   );

   // configuration and frame counters
   always_comb begin
      src_step_in     = src_step_ff;
      res_phases_in   = res_phases_ff;
      next_phase_in   = next_phase_ff;
      phase_prod_in   = phase_prod_ff;
      sample_bound_in = sample_bound_ff;
      frame_pos_in    = frame_pos_ff;
      burst_cnt_in    = burst_cnt_ff;
      cptr_in         = cptr_ff;
      frame_pos_next  = (STEP_W + 1)'(frame_pos_ff) + 1'b1;
      bound_sum_next  = bound_sum;

      if (hist_wr) burst_cnt_in = '0;

      // one tap a cycle walks the coefficient row
      if (mac_issue) cptr_in = cptr_ff + 1'b1;

      // a result moves to the next phase
      if (rsp_load) begin
         next_phase_in = next_phase_ff + 1'b1;
         phase_prod_in = prod_next[CNT_W-1:0];
         burst_cnt_in  = burst_cnt_ff + 1'b1;
      end

      // end of the sample item: advance the frame
      if (frame_step) begin
         if (frame_pos_next >= (STEP_W + 1)'(p_eff)) begin
            next_phase_in   = '0;
            phase_prod_in   = '0;
            sample_bound_in = '0;
            frame_pos_in    = '0;
            cptr_in         = '0;
         end else begin
            frame_pos_in    = frame_pos_next[STEP_W-1:0];
            sample_bound_in = bound_sum_next[CNT_W-1:0];
         end
      end

      // register writes restart the frame
      if (csr_we) begin
         case (csr_index)
            REG_SOURCE_STEP:   src_step_in   = csr_wdata;
            REG_RESULT_PHASES: res_phases_in = csr_wdata;
            default: begin
            end
         endcase
         next_phase_in   = '0;
         phase_prod_in   = '0;
         sample_bound_in = '0;
         frame_pos_in    = '0;
         cptr_in         = '0;
      end
   end

   // history pointers and valid bits
   always_comb begin
      wptr_in       = wptr_ff;
      hptr_in       = hptr_ff;
      tap_in        = tap_ff;
      hist_valid_in = hist_valid_ff;
      if (hist_wr) begin
         hist_valid_in[wptr_ff] = 1'b1;
         wptr_in = (wptr_ff == HIST_AW'(TAP_COUNT - 1)) ? '0 : wptr_ff + 1'b1;
      end
      // oldest sample sits at the write pointer
      if (mac_start) begin
         hptr_in = wptr_ff;
         tap_in  = '0;
      end else if (mac_issue) begin
         hptr_in = (hptr_ff == HIST_AW'(TAP_COUNT - 1)) ? '0 : hptr_ff + 1'b1;
         tap_in  = tap_ff + 1'b1;
      end
   end

   // accumulator
   always_comb begin
      acc_in = acc_ff;
      if (mac_start) begin
         acc_in = '0;
      end else if (prod_valid_ff) begin
         acc_in = acc_ff + ACC_W'(prod_ff);
      end
   end

   // round half up and saturate
   assign acc_bias  = (ACC_W + 1)'(acc_ff) + (ACC_W + 1)'(ROUND_BIAS);
   assign acc_shift = acc_bias[ACC_W:FRAC_SHIFT];
   always_comb begin
      if (acc_shift > SAT_HI) begin
         acc_sat = SAT_HI[SAMPLE_W-1:0];
      end else if (acc_shift < SAT_LO) begin
         acc_sat = SAT_LO[SAMPLE_W-1:0];
      end else begin
         acc_sat = acc_shift[SAMPLE_W-1:0];
      end
   end

   // result handshake
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         src_step_ff     <= CFG_W'(1);
         res_phases_ff   <= CFG_W'(1);
         next_phase_ff   <= '0;
         phase_prod_ff   <= '0;
         sample_bound_ff <= '0;
         frame_pos_ff    <= '0;
         burst_cnt_ff    <= '0;
         cptr_ff         <= '0;
         wptr_ff         <= '0;
         hptr_ff         <= '0;
         tap_ff          <= '0;
         hist_valid_ff   <= '0;
         rd_valid_ff     <= 1'b0;
         prod_valid_ff   <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         src_step_ff     <= src_step_in;
         res_phases_ff   <= res_phases_in;
         next_phase_ff   <= next_phase_in;
         phase_prod_ff   <= phase_prod_in;
         sample_bound_ff <= sample_bound_in;
         frame_pos_ff    <= frame_pos_in;
         burst_cnt_ff    <= burst_cnt_in;
         cptr_ff         <= cptr_in;
         wptr_ff         <= wptr_in;
         hptr_ff         <= hptr_in;
         tap_ff          <= tap_in;
         hist_valid_ff   <= hist_valid_in;
         rd_valid_ff     <= mac_issue;
         prod_valid_ff   <= rd_valid_ff;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (mac_issue) begin
         hval_ff <= hist_valid_ff[hptr_ff];
      end
      prod_ff <= coef_rd * (hval_ff ? hist_rd : SAMPLE_W'(0));
      acc_ff  <= acc_in;
      if (rsp_load) begin
         rsp_sample_ff <= acc_sat;
         rsp_last_ff   <= !more_ok;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_sample_ff;
   assign rsp_last       = rsp_last_ff;

endmodule

`default_nettype wire

// ===== rtl/prr_ram.sv =====
// generic simple dual-port ram with one write port and a registered read port
`default_nettype none

module prr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire
